// ===== rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: sorted list table shared definitions
// Opcodes, status codes and the request and response item layouts.
// ----------------------------------------------------------------------------
package slt_pkg;

   localparam int OPCODE_WIDTH   = 3;
   localparam int KEY_FIELD_WIDTH = 32;
   localparam int POS_WIDTH      = 5;
   localparam int STATUS_WIDTH   = 2;

   localparam logic [OPCODE_WIDTH-1:0] OP_INSERT     = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_REMOVE_KEY = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_REMOVE_AT  = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_READ_AT    = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_FIND       = 3'd4;
   localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR      = 3'd5;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0]    opcode;
      logic [KEY_FIELD_WIDTH-1:0] key;
      logic [POS_WIDTH-1:0]       position;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]    status;
      logic [KEY_FIELD_WIDTH-1:0] read_key;
      logic [POS_WIDTH-1:0]       found_position;
      logic [POS_WIDTH-1:0]       entry_count;
   } rsp_payload_type;

endpackage

// ===== rtl/slt_chan_if.sv =====
// ----------------------------------------------------------------------------
// slt_chan_if: valid/ready channel
// Carries one payload item per handshake; source drives, sink accepts.
// ----------------------------------------------------------------------------
interface slt_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/slt_key_ram.sv =====
// ----------------------------------------------------------------------------
// slt_key_ram: key storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slt_key_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] key_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= key_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/sorted_list_table.sv =====
// ----------------------------------------------------------------------------
// sorted_list_table: bounded ascending key table
// Sequencer that walks the key memory one entry a cycle through one compare.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries an item {opcode, key, position}; rsp_ch returns exactly one
//   item {status, read_key, found_position, entry_count} per request, in order.
//   Both are valid/ready channels; an item moves when valid and ready are high.
//   Insert walks down from the top entry, moving keys not smaller than it up one
//   slot until the insertion point; remove walks up and moves later entries down
//   one slot. Find and remove-by-key scan up from the first entry; the indexed
//   operations start at the given position. The memory has one registered read
//   port. The block is ready for the next request in the cycle after the result
//   is handed to the output register, and takes no new request while one is in
//   progress. A result waiting in the output register does not block a new
//   request; if rsp_ch stays stalled, the next result holds in the sequencer.
//   Reset (synchronous) empties the table and drops any pending result; the
//   key memory is not cleared and needs no init pass.
// ----------------------------------------------------------------------------
module sorted_list_table #(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   slt_chan_if.sink   req_ch,
   slt_chan_if.source rsp_ch
);
   import slt_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_SCAN_UP   = 2'd1;
   localparam logic [1:0] ST_SCAN_DOWN = 2'd2;
   localparam logic [1:0] ST_FINISH    = 2'd3;

   // control state
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          chk_valid_ff, chk_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // working payload
   logic [OPCODE_WIDTH-1:0] op_ff, op_in;
   logic [KEY_WIDTH-1:0]    key_ff, key_in;
   logic [CW-1:0]           rd_idx_ff, rd_idx_in;
   logic [AW-1:0]           chk_idx_ff, chk_idx_in;
   logic                    shifting_ff, shifting_in;
   logic [STATUS_WIDTH-1:0] res_status_ff, res_status_in;
   logic [KEY_FIELD_WIDTH-1:0] res_rkey_ff, res_rkey_in;
   logic [POS_WIDTH-1:0]    res_fpos_ff, res_fpos_in;
   rsp_payload_type         rsp_payload_ff, rsp_payload_in;

   // memory port
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [KEY_WIDTH-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [KEY_WIDTH-1:0] ram_rd_data;

   // helpers
   logic [KEY_WIDTH+KEY_FIELD_WIDTH-1:0] key_wide;
   logic [KEY_WIDTH+KEY_FIELD_WIDTH-1:0] rdata_wide;
   logic [CW+POS_WIDTH-1:0]              pos_wide;
   logic [CW+POS_WIDTH-1:0]              cnt_wide;
   logic [CW+POS_WIDTH-1:0]              pos_start_wide;
   logic [AW:0]                          chk_next;
   logic [AW+POS_WIDTH:0]                fpos_wide;
   logic [CW-1:0]                        rd_dec;
   logic                                 pos_ok;
   logic                                 cmp_eq;
   logic                                 cmp_ge;

   function automatic logic [POS_WIDTH-1:0] count_wide_lo(input logic [CW-1:0] cnt);
      logic [CW+POS_WIDTH-1:0] wide;
      wide = {{POS_WIDTH{1'b0}}, cnt};
      return wide[POS_WIDTH-1:0];
   endfunction

   slt_key_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_WIDTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign key_wide       = {{KEY_WIDTH{1'b0}}, req_ch.payload.key};
   assign rdata_wide     = {{KEY_FIELD_WIDTH{1'b0}}, ram_rd_data};
   assign pos_wide       = {{CW{1'b0}}, req_ch.payload.position};
   assign cnt_wide       = {{POS_WIDTH{1'b0}}, count_ff};
   assign pos_start_wide = pos_wide - 1'b1;
   assign pos_ok         = (req_ch.payload.position != '0) && (pos_wide <= cnt_wide);
   assign chk_next       = {1'b0, chk_idx_ff} + 1'b1;
   assign fpos_wide      = {{POS_WIDTH{1'b0}}, chk_next};
   assign rd_dec         = rd_idx_ff - 1'b1;

   // shared compare unit
   assign cmp_eq = (ram_rd_data == key_ff);
   assign cmp_ge = (ram_rd_data >= key_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      chk_valid_in   = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      rd_idx_in      = rd_idx_ff;
      chk_idx_in     = chk_idx_ff;
      shifting_in    = shifting_ff;
      res_status_in  = res_status_ff;
      res_rkey_in    = res_rkey_ff;
      res_fpos_in    = res_fpos_ff;
      rsp_payload_in = rsp_payload_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = chk_next[AW-1:0];
      ram_wr_data    = key_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rd_idx_ff[AW-1:0];

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in         = req_ch.payload.opcode;
               key_in        = key_wide[KEY_WIDTH-1:0];
               shifting_in   = 1'b0;
               res_status_in = STATUS_OK;
               res_rkey_in   = '0;
               res_fpos_in   = '0;
               case (req_ch.payload.opcode)
                  OP_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        res_status_in = STATUS_FULL;
                        state_in      = ST_FINISH;
                     end else begin
                        rd_idx_in = count_ff;
                        state_in  = ST_SCAN_DOWN;
                     end
                  end
                  OP_REMOVE_KEY, OP_FIND: begin
                     rd_idx_in = '0;
                     state_in  = ST_SCAN_UP;
                  end
                  OP_REMOVE_AT, OP_READ_AT: begin
                     if (pos_ok) begin
                        rd_idx_in = pos_start_wide[CW-1:0];
                        state_in  = ST_SCAN_UP;
                     end else begin
                        res_status_in = STATUS_MISS;
                        state_in      = ST_FINISH;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     res_status_in = STATUS_MISS;
                     state_in      = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN_UP: begin
            if (rd_idx_ff < count_ff) begin
               ram_rd_en    = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff[AW-1:0];
               rd_idx_in    = rd_idx_ff + 1'b1;
            end
            if (chk_valid_ff) begin
               case (op_ff)
                  OP_FIND: begin
                     if (cmp_eq) begin
                        res_fpos_in = fpos_wide[POS_WIDTH-1:0];
                        state_in    = ST_FINISH;
                     end
                  end
                  OP_READ_AT: begin
                     res_rkey_in = rdata_wide[KEY_FIELD_WIDTH-1:0];
                     state_in    = ST_FINISH;
                  end
                  default: begin
                     // remove: drop the matching entry, move later ones down
                     if (shifting_ff) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = chk_idx_ff - 1'b1;
                        ram_wr_data = ram_rd_data;
                     end else if (op_ff == OP_REMOVE_AT || cmp_eq) begin
                        shifting_in = 1'b1;
                     end
                  end
               endcase
            end else if (rd_idx_ff >= count_ff) begin
               if (shifting_ff) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  res_status_in = STATUS_MISS;
               end
               state_in = ST_FINISH;
            end
         end

         ST_SCAN_DOWN: begin
            ram_rd_addr = rd_dec[AW-1:0];
            if (rd_idx_ff != '0) begin
               ram_rd_en    = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_dec[AW-1:0];
               rd_idx_in    = rd_dec;
            end
            if (chk_valid_ff) begin
               ram_wr_en = 1'b1;
               if (cmp_ge) begin
                  ram_wr_data = ram_rd_data;
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = ST_FINISH;
               end
            end else if (rd_idx_ff == '0) begin
               // every stored key is not smaller: place at the bottom
               ram_wr_en   = 1'b1;
               ram_wr_addr = '0;
               count_in    = count_ff + 1'b1;
               state_in    = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_payload_in.status         = res_status_ff;
               rsp_payload_in.read_key       = res_rkey_ff;
               rsp_payload_in.found_position = res_fpos_ff;
               rsp_payload_in.entry_count    = count_wide_lo(count_ff);
               rsp_valid_in                  = 1'b1;
               state_in                      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      rd_idx_ff      <= rd_idx_in;
      chk_idx_ff     <= chk_idx_in;
      shifting_ff    <= shifting_in;
      res_status_ff  <= res_status_in;
      res_rkey_ff    <= res_rkey_in;
      res_fpos_ff    <= res_fpos_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;
endmodule

// ===== tb/sv/slt_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slt_table_checker: sorted list table response checker
// Watches the request and response channels, keeps its own ordered key table
// to predict each response, and compares every response field by field.
// ----------------------------------------------------------------------------
module slt_table_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  slt_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  slt_pkg::rsp_payload_type rsp_payload,
   output int                       error_count,
   output int                       pending_count,
   output int                       result_count,
   output int                       full_drops,
   output int                       key_hits
);
   import slt_pkg::*;

   localparam int MAX_REPORTS = 10;

   logic [KEY_FIELD_WIDTH-1:0] table_keys [CAPACITY];
   int                         table_count;
   rsp_payload_type            expected_rsp_q [$];

   function automatic int locate_key(logic [KEY_FIELD_WIDTH-1:0] key);
      for (int i = 0; i < table_count; i++) begin
         if (table_keys[i] == key) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void drop_slot(int slot);
      for (int i = slot; i + 1 < table_count; i++) begin
         table_keys[i] = table_keys[i + 1];
      end
      table_count--;
   endfunction

   // Update the table for one request and return the response it produces.
   function automatic rsp_payload_type apply_request(req_payload_type item);
      rsp_payload_type res;
      int              slot;
      res = '0;
      res.status = STATUS_OK;
      case (item.opcode)
         OP_INSERT: begin
            if (table_count >= CAPACITY) begin
               res.status = STATUS_FULL;
               full_drops++;
            end else begin
               // equal keys go before the ones already stored
               slot = 0;
               while (slot < table_count && table_keys[slot] < item.key) begin
                  slot++;
               end
               for (int i = table_count; i > slot; i--) begin
                  table_keys[i] = table_keys[i - 1];
               end
               table_keys[slot] = item.key;
               table_count++;
            end
         end
         OP_REMOVE_KEY: begin
            slot = locate_key(item.key);
            if (slot < 0) begin
               res.status = STATUS_MISS;
            end else begin
               drop_slot(slot);
               key_hits++;
            end
         end
         OP_REMOVE_AT: begin
            if (item.position >= 1 && item.position <= table_count) begin
               drop_slot(item.position - 1);
            end else begin
               res.status = STATUS_MISS;
            end
         end
         OP_READ_AT: begin
            if (item.position >= 1 && item.position <= table_count) begin
               res.read_key = table_keys[item.position - 1];
            end else begin
               res.status = STATUS_MISS;
            end
         end
         OP_FIND: begin
            slot = locate_key(item.key);
            if (slot < 0) begin
               res.status = STATUS_MISS;
            end else begin
               res.found_position = POS_WIDTH'(slot + 1);
               key_hits++;
            end
         end
         OP_CLEAR: begin
            table_count = 0;
         end
         default: begin
            res.status = STATUS_MISS;
         end
      endcase
      res.entry_count = POS_WIDTH'(table_count);
      return res;
   endfunction

   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         if (error_count < MAX_REPORTS) begin
            $display("[%0t] response %0d: %s expected 0x%0h, got 0x%0h",
                     $realtime, result_count, field, want, got);
         end
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         expected_rsp_q.delete();
         table_count = 0;
      end else begin
         // retire the response before queuing a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               if (error_count < MAX_REPORTS) begin
                  $display("[%0t] response with no request outstanding: 0x%0h",
                           $realtime, rsp_payload);
               end
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("status", want.status, rsp_payload.status);
               check_field("read_key", want.read_key, rsp_payload.read_key);
               check_field("found_position", want.found_position,
                           rsp_payload.found_position);
               check_field("entry_count", want.entry_count, rsp_payload.entry_count);
               result_count++;
            end
         end
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(apply_request(req_payload));
         end
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: sorted list table testbench
// Drives a directed sequence and then random request batches biased toward
// filling, draining or mixing the table, with random gaps and back-pressure;
// the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
   import slt_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int KEY_WIDTH    = 32;
   localparam int RANDOM_ITEMS = 1350;
   localparam int BATCH_ITEMS  = 40;
   localparam int DRAIN_CYCLES = CAPACITY + 8;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED_HI = 3'd7;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_kind_type;

   logic              clock;
   logic              reset;
   int unsigned       cycles;
   int                sent_count;
   logic              quiet_sender;
   logic [KEY_FIELD_WIDTH-1:0] recent_keys [CAPACITY];
   int                recent_wr;

   int error_count;
   int pending_count;
   int result_count;
   int full_drops;
   int key_hits;

   slt_chan_if #(.payload_type(req_payload_type)) req_if ();
   slt_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   sorted_list_table #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   slt_table_checker #(
      .CAPACITY (CAPACITY)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_payload   (req_if.payload),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_payload   (rsp_if.payload),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .full_drops    (full_drops),
      .key_hits      (key_hits)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycles, pending_count);
      $display("** sorted_list_table: FAILED **");
      $finish;
   end

   // Response side: random stalls, one long hold-off so the block backs up,
   // and one long stretch always ready.
   initial begin
      int unsigned since_reset;
      since_reset = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         since_reset++;
         if (since_reset >= 2000 && since_reset < 2400) begin
            rsp_if.ready <= 1'b0;
         end else if (since_reset >= 6000 && since_reset < 9000) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= 25);
         end
         @(posedge clock);
      end
   end

   task automatic send_request(input logic [OPCODE_WIDTH-1:0] opcode,
                               input logic [KEY_FIELD_WIDTH-1:0] key,
                               input logic [POS_WIDTH-1:0] position);
      req_payload_type item;
      int              gap;
      item.opcode   = opcode;
      item.key      = key;
      item.position = position;
      gap = 0;
      if (!quiet_sender && $urandom_range(99) < 25) begin
         gap = $urandom_range(1, 4);
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
      if (opcode == OP_INSERT) begin
         recent_keys[recent_wr] = key;
         recent_wr = (recent_wr + 1) % CAPACITY;
      end
   endtask

   // Small keys collide often, recent keys hit on find and remove.
   function automatic logic [KEY_FIELD_WIDTH-1:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) begin
         return $urandom_range(0, 23);
      end else if (roll < 60) begin
         return recent_keys[$urandom_range(CAPACITY - 1)];
      end else if (roll < 75) begin
         case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [OPCODE_WIDTH-1:0] pick_opcode(phase_kind_type phase);
      int roll;
      roll = $urandom_range(199);
      if (roll < 2) return OP_CLEAR;
      if (roll < 3) return OP_UNUSED_LO;
      if (roll < 4) return OP_UNUSED_HI;
      roll = $urandom_range(99);
      case (phase)
         PHASE_FILL: begin
            if (roll < 70) return OP_INSERT;
            if (roll < 78) return OP_FIND;
            if (roll < 86) return OP_READ_AT;
            if (roll < 93) return OP_REMOVE_KEY;
            return OP_REMOVE_AT;
         end
         PHASE_DRAIN: begin
            if (roll < 20) return OP_INSERT;
            if (roll < 45) return OP_REMOVE_KEY;
            if (roll < 65) return OP_REMOVE_AT;
            if (roll < 82) return OP_FIND;
            return OP_READ_AT;
         end
         default: begin
            if (roll < 40) return OP_INSERT;
            if (roll < 55) return OP_REMOVE_KEY;
            if (roll < 65) return OP_REMOVE_AT;
            if (roll < 82) return OP_FIND;
            return OP_READ_AT;
         end
      endcase
   endfunction

   function automatic logic [POS_WIDTH-1:0] pick_position();
      if ($urandom_range(99) < 85) begin
         return POS_WIDTH'($urandom_range(0, CAPACITY + 1));
      end
      return POS_WIDTH'($urandom_range(0, 31));
   endfunction

   initial begin
      phase_kind_type phase;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      reset          <= 1'b1;
      quiet_sender = 1'b0;
      sent_count   = 0;
      recent_wr    = 0;
      phase        = PHASE_MIXED;
      foreach (recent_keys[i]) recent_keys[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty table: every lookup misses, clear still succeeds
      send_request(OP_READ_AT, '0, 5'd1);
      send_request(OP_FIND, '0, 5'd0);
      send_request(OP_REMOVE_KEY, '0, 5'd0);
      send_request(OP_REMOVE_AT, '0, 5'd1);
      send_request(OP_CLEAR, '0, 5'd0);
      // extremes and a duplicate
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_INSERT, 32'h0000_0000, 5'd0);
      send_request(OP_INSERT, 32'h0000_0000, 5'd0);
      send_request(OP_INSERT, 32'h8000_0000, 5'd0);
      send_request(OP_INSERT, 32'h0000_0005, 5'd0);
      send_request(OP_FIND, 32'h0000_0000, 5'd0);
      send_request(OP_FIND, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_FIND, 32'h0000_0006, 5'd0);
      // position zero, in range, one past the count and far out
      send_request(OP_READ_AT, '0, 5'd0);
      send_request(OP_READ_AT, '0, 5'd5);
      send_request(OP_READ_AT, '0, 5'd6);
      send_request(OP_READ_AT, '1, 5'd31);
      send_request(OP_REMOVE_KEY, 32'h0000_0000, 5'd0);
      send_request(OP_REMOVE_AT, '0, 5'd4);
      send_request(OP_REMOVE_AT, '0, 5'd17);
      send_request(OP_UNUSED_LO, 32'hA5A5_5A5A, 5'd31);
      send_request(OP_UNUSED_HI, 32'h5A5A_A5A5, 5'd1);
      // single entry: removed only by an equal key
      send_request(OP_CLEAR, '0, 5'd0);
      send_request(OP_INSERT, 32'h0000_0009, 5'd0);
      send_request(OP_REMOVE_KEY, 32'h0000_0008, 5'd0);
      send_request(OP_REMOVE_KEY, 32'h0000_0009, 5'd0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % BATCH_ITEMS == 0) begin
            phase = phase_kind_type'($urandom_range(2));
         end
         quiet_sender = (n >= 300 && n < 600);
         send_request(pick_opcode(phase), pick_key(), pick_position());
      end
      req_if.valid <= 1'b0;

      // let the checker see the last accept before reading its counts
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses in %0d cycles", sent_count,
               result_count, cycles);
      $display("Inserts dropped on a full table: %0d, key lookups that hit: %0d",
               full_drops, key_hits);
      if (error_count == 0 && pending_count == 0) begin
         $display("** sorted_list_table: PASSED **");
      end else begin
         $display("** sorted_list_table: FAILED **");
      end
      $finish;
   end

endmodule
